// ===== design/rpf_pkg.sv =====
// shared constants and types of the record packet framer
`default_nettype none
package rpf_pkg;
	localparam int TOTAL_RECORDS      = 1024;
	localparam int RECORDS_PER_PACKET = 100;

	localparam int OFF_W = 11;
	localparam int RIP_W = 7;
	// widest packet is 708 bytes of at most 0xff00 each, fits in 26 bits
	localparam int SUM_W = 26;
	localparam int IDX_W = 5;

	localparam logic [7:0] CHAR_D = 8'h44;
	localparam logic [7:0] CHAR_P = 8'h50;

	// byte positions of the per-record output sequence
	localparam logic [IDX_W-1:0] IDX_HDR_FIRST = 5'd0;
	localparam logic [IDX_W-1:0] IDX_REC_FIRST = 5'd8;
	localparam logic [IDX_W-1:0] IDX_REC_LAST  = 5'd14;
	localparam logic [IDX_W-1:0] IDX_CS_HI     = 5'd15;
	localparam logic [IDX_W-1:0] IDX_CS_LO     = 5'd16;

	typedef struct packed {
		logic             hdr;
		logic             rip_odd;
		logic             close;
		logic [OFF_W-1:0] off;
		logic [7:0]       fault_code;
		logic [15:0]      delta_time;
		logic [15:0]      read_value;
		logic [15:0]      written_value;
	} rpf_cmd_t;
endpackage
`default_nettype wire

// ===== design/rpf_front.sv =====
// front end: takes records, tracks offset and packet fill, queues byte jobs
`default_nettype none
module rpf_front import rpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata, // fault_code, delta_time, read_value, written_value
	input  wire logic        s_tuser, // start_of_dump
	input  wire logic        q_full,
	output logic             q_push,
	output rpf_cmd_t         q_cmd
);
	localparam int RIPC_W = RIP_W + 1;
	localparam int OFFC_W = OFF_W + 1;

	logic [OFF_W-1:0]  off_q;
	logic [RIP_W-1:0]  rip_q;
	logic [OFF_W-1:0]  off;
	logic [RIP_W-1:0]  rip;
	logic [RIPC_W-1:0] rip_next;
	logic [OFFC_W-1:0] off_next;
	logic              full_pkt;
	logic              dump_done;

	always_comb begin
		off       = s_tuser ? '0 : off_q;
		rip       = s_tuser ? '0 : rip_q;
		rip_next  = RIPC_W'(rip) + RIPC_W'(1);
		off_next  = OFFC_W'(off) + OFFC_W'(1);
		full_pkt  = rip_next >= RIPC_W'(RECORDS_PER_PACKET);
		dump_done = off_next >= OFFC_W'(TOTAL_RECORDS);
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_cmd.hdr           = rip == '0;
		q_cmd.rip_odd       = rip[0];
		q_cmd.close         = full_pkt || dump_done;
		q_cmd.off           = off;
		q_cmd.fault_code    = s_tdata[7:0];
		q_cmd.delta_time    = s_tdata[23:8];
		q_cmd.read_value    = s_tdata[39:24];
		q_cmd.written_value = s_tdata[55:40];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			rip_q <= '0;
		end else if (q_push) begin
			rip_q <= (full_pkt || dump_done) ? '0 : rip_next[RIP_W-1:0];
			off_q <= dump_done ? '0 : off_next[OFF_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== design/rpf_queue.sv =====
// two-entry job queue between front and back
`default_nettype none
module rpf_queue import rpf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  rpf_cmd_t      push_cmd,
	output logic          full,
	input  wire logic     pop,
	output rpf_cmd_t      head,
	output logic          empty
);
	rpf_cmd_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/rpf_back.sv =====
// back end: serializes a job into bytes, keeps the weighted sum, adds checksum
`default_nettype none
module rpf_back import rpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  rpf_cmd_t         cmd,
	input  wire logic        cmd_empty,
	output logic             cmd_pop,
	input  wire logic [31:0] dump_timestamp,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata, // out_byte
	output logic             m_tlast, // packet_end
	output logic             m_tuser  // run_end
);
	logic             started_q;
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] sum_q;
	logic             m_tvalid_q;
	logic [7:0]       data_q;
	logic             last_q;
	logic             user_q;

	logic [IDX_W-1:0] idx;
	logic             adv;
	logic             is_last;
	logic             odd;
	logic [7:0]       b;
	logic [15:0]      cs;
	logic [SUM_W-1:0] weighted;

	always_comb begin
		if (started_q) begin
			idx = idx_q;
		end else begin
			idx = cmd.hdr ? IDX_HDR_FIRST : IDX_REC_FIRST;
		end
		adv     = !cmd_empty && (!m_tvalid_q || m_tready);
		is_last = cmd.close ? (idx == IDX_CS_LO) : (idx == IDX_REC_LAST);
		cmd_pop = adv && is_last;
		// record bytes shift parity with the number of records before them
		odd     = idx[0] ^ (idx >= IDX_REC_FIRST && cmd.rip_odd);
		// partial fold of bits 16..19 back into the low half
		cs      = ~(sum_q[15:0] + {12'd0, sum_q[19:16]});
		unique case (idx)
			5'd0:    b = CHAR_D;
			5'd1:    b = CHAR_P;
			5'd2:    b = {5'd0, cmd.off[OFF_W-1:8]};
			5'd3:    b = cmd.off[7:0];
			5'd4:    b = dump_timestamp[31:24];
			5'd5:    b = dump_timestamp[23:16];
			5'd6:    b = dump_timestamp[15:8];
			5'd7:    b = dump_timestamp[7:0];
			5'd8:    b = cmd.fault_code;
			5'd9:    b = cmd.delta_time[15:8];
			5'd10:   b = cmd.delta_time[7:0];
			5'd11:   b = cmd.read_value[15:8];
			5'd12:   b = cmd.read_value[7:0];
			5'd13:   b = cmd.written_value[15:8];
			5'd14:   b = cmd.written_value[7:0];
			5'd15:   b = cs[15:8];
			5'd16:   b = cs[7:0];
			default: b = 8'd0;
		endcase
		weighted = odd ? SUM_W'(b) : SUM_W'({b, 8'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid_q <= 1'b1;
				started_q  <= !is_last;
				idx_q      <= idx + IDX_W'(1);
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= b;
			last_q <= cmd.close && idx == IDX_CS_LO;
			user_q <= is_last;
			if (idx == IDX_HDR_FIRST) begin
				sum_q <= weighted;
			end else if (idx < IDX_CS_HI) begin
				sum_q <= sum_q + weighted;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;
endmodule
`default_nettype wire

// ===== design/record_packet_framer_checksum.sv =====
// top level of the record packet framer
`default_nettype none
// Packs 7-byte monitoring records into packets and streams them out one byte
// per word: header 'D','P', 16-bit record offset and 32-bit dump timestamp,
// then the records, then a 16-bit checksum (even positions weighted by 256,
// bits 16..19 folded once, inverted). A record yields 7 output bytes, 15 when
// it opens a packet and 2 more when it closes one. Records are queued two
// deep ahead of the serializer, so input and output stall independently.
// m_tlast marks the last checksum byte of a packet, m_tuser the last byte
// caused by a record. Write dump_timestamp only while no record is in flight.
module record_packet_framer_checksum import rpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data, // dump_timestamp
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // fault_code, delta_time, read_value, written_value
	input  wire logic        s_tuser,  // start_of_dump
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // out_byte
	output logic             m_tlast,  // packet_end
	output logic             m_tuser   // run_end
);
	logic [31:0] ts_q;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	rpf_cmd_t    q_in;
	rpf_cmd_t    q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= '0;
		end else if (cfg_valid) begin
			ts_q <= cfg_data;
		end
	end

	rpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_in)
	);

	rpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	rpf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (q_head),
		.cmd_empty      (q_empty),
		.cmd_pop        (q_pop),
		.dump_timestamp (ts_q),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser)
	);
endmodule
`default_nettype wire

// ===== sim/framer_check.sv =====
// checker for the record packet framer: predicts packet bytes and compares the output stream
`timescale 1ns / 1ps
module framer_check import rpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [31:0] cfg_data,  // dump_timestamp
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [55:0] s_tdata,   // fault_code, delta_time, read_value, written_value
	input  wire logic        s_tuser,   // start_of_dump
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,   // out_byte
	input  wire logic        m_tlast,   // packet_end
	input  wire logic        m_tuser,   // run_end
	output int               errors,
	output int               outstanding,
	output int               records_seen,
	output int               packets_seen,
	output int               bytes_seen,
	output int               dump_wraps
);

	typedef struct packed {
		logic [7:0] data;
		logic       packet_end;
		logic       run_end;
	} framer_byte_t;

	framer_byte_t packet_bytes_due[$];
	framer_byte_t due;
	framer_byte_t got;

	logic [31:0] stamp;
	int          rec_off;
	int          rec_in_pkt;
	logic [31:0] pkt_sum;
	int          err_cnt;

	task automatic log_mismatch(input string msg);
		if (err_cnt < 10)
			$display("mismatch: %s", msg);
		err_cnt++;
	endtask

	// weighted sum: even positions count times 256
	task automatic add_byte(input logic [7:0] b, input int pos);
		framer_byte_t w;
		pkt_sum = pkt_sum + ((pos % 2) ? {24'd0, b} : {16'd0, b, 8'd0});
		w.data = b;
		w.packet_end = 1'b0;
		w.run_end = 1'b0;
		packet_bytes_due.push_back(w);
	endtask

	task automatic frame_record(input logic sod, input logic [55:0] d);
		logic [31:0]  s;
		logic [15:0]  cs;
		int           off;
		int           pos;
		framer_byte_t w;
		if (sod) begin
			rec_off = 0;
			rec_in_pkt = 0;
			pkt_sum = '0;
		end
		off = rec_off;
		if (rec_in_pkt == 0) begin
			pkt_sum = '0;
			add_byte(CHAR_D, 0);
			add_byte(CHAR_P, 1);
			add_byte(8'(off >> 8), 2);
			add_byte(8'(off), 3);
			add_byte(stamp[31:24], 4);
			add_byte(stamp[23:16], 5);
			add_byte(stamp[15:8], 6);
			add_byte(stamp[7:0], 7);
		end
		pos = 8 + 7 * rec_in_pkt;
		add_byte(d[7:0], pos);
		add_byte(d[23:16], pos + 1);
		add_byte(d[15:8], pos + 2);
		add_byte(d[39:32], pos + 3);
		add_byte(d[31:24], pos + 4);
		add_byte(d[55:48], pos + 5);
		add_byte(d[47:40], pos + 6);
		rec_in_pkt++;
		rec_off = off + 1;
		if (rec_in_pkt >= RECORDS_PER_PACKET || rec_off >= TOTAL_RECORDS) begin
			// single partial fold of bits 16..19, then invert
			s = pkt_sum + ((pkt_sum >> 16) & 32'hF);
			cs = ~s[15:0];
			w.data = cs[15:8];
			w.packet_end = 1'b0;
			w.run_end = 1'b0;
			packet_bytes_due.push_back(w);
			w.data = cs[7:0];
			w.packet_end = 1'b1;
			packet_bytes_due.push_back(w);
			rec_in_pkt = 0;
			pkt_sum = '0;
			if (rec_off >= TOTAL_RECORDS) begin
				rec_off = 0;
				dump_wraps <= dump_wraps + 1;
			end
		end
		rec_off = rec_off & 32'h7FF;
		w = packet_bytes_due.pop_back();
		w.run_end = 1'b1;
		packet_bytes_due.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_bytes_due.delete();
			stamp = '0;
			rec_off = 0;
			rec_in_pkt = 0;
			pkt_sum = '0;
			err_cnt = 0;
			errors <= 0;
			outstanding <= 0;
			records_seen <= 0;
			packets_seen <= 0;
			bytes_seen <= 0;
			dump_wraps <= 0;
		end else begin
			// output side first so a word never meets its own record's bytes
			if (m_tvalid && m_tready) begin
				got.data = m_tdata;
				got.packet_end = m_tlast;
				got.run_end = m_tuser;
				if (packet_bytes_due.size() == 0) begin
					log_mismatch($sformatf("unexpected word %02h last %0b user %0b",
						got.data, got.packet_end, got.run_end));
				end else begin
					due = packet_bytes_due.pop_front();
					if (due != got)
						log_mismatch($sformatf(
							"word %0d expected %02h last %0b user %0b, got %02h last %0b user %0b",
							bytes_seen, due.data, due.packet_end, due.run_end,
							got.data, got.packet_end, got.run_end));
				end
				bytes_seen <= bytes_seen + 1;
				if (m_tlast)
					packets_seen <= packets_seen + 1;
			end
			if (cfg_valid && cfg_ready)
				stamp = cfg_data;
			if (s_tvalid && s_tready) begin
				frame_record(s_tuser, s_tdata);
				records_seen <= records_seen + 1;
			end
			outstanding <= packet_bytes_due.size();
			errors <= err_cnt;
		end
	end

endmodule

// ===== sim/tb_record_packet_framer_checksum.sv =====
// testbench top for the record packet framer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_record_packet_framer_checksum import rpf_pkg::*;;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_AT     = 12;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	int errors;
	int outstanding;
	int records_seen;
	int packets_seen;
	int bytes_seen;
	int dump_wraps;

	int send_idle_pct;
	int recv_idle_pct;
	int quiet;
	int words_in;
	int hold_left;
	bit hold_done;

	record_packet_framer_checksum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	framer_check check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.errors       (errors),
		.outstanding  (outstanding),
		.records_seen (records_seen),
		.packets_seen (packets_seen),
		.bytes_seen   (bytes_seen),
		.dump_wraps   (dump_wraps)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls plus one long hold-off once the input is busy
	initial m_tready = 1'b0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			words_in <= words_in + 1;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && words_in == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet);
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic logic [55:0] pack_record(input logic [7:0] fc, input logic [15:0] dt,
			input logic [15:0] rd, input logic [15:0] wr);
		return {wr, rd, dt, fc};
	endfunction

	// mostly random, with the extremes showing up often
	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_record(input logic sod, input logic [55:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= sod;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// a run of records, optionally opened by start_of_dump, with occasional restarts
	task automatic send_dump(input int n, input int restart_pct, input logic first_sod);
		logic sod;
		for (int i = 0; i < n; i++) begin
			sod = (i == 0 && first_sod) || ($urandom_range(0, 99) < restart_pct);
			send_record(sod, pack_record(8'(pick16()), pick16(), pick16(), pick16()));
		end
	endtask

	// only while nothing is in flight
	task automatic write_stamp(input logic [31:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 73;
		words_in = 0;
		hold_left = 0;
		hold_done = 1'b0;
		quiet = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_stamp(32'hFFFF_FFFF);
		send_record(1'b1, pack_record(8'h00, 16'h0000, 16'h0000, 16'h0000));
		send_record(1'b0, pack_record(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_record(1'b0, pack_record(8'hAA, 16'hAAAA, 16'h5555, 16'hAAAA));
		send_record(1'b0, pack_record(8'h55, 16'h5555, 16'hAAAA, 16'h5555));
		// restart while a packet is open, then again right after a header
		send_record(1'b1, pack_record(8'h01, 16'h8000, 16'h0001, 16'h7FFF));
		send_record(1'b1, pack_record(8'h80, 16'h00FF, 16'hFF00, 16'h1234));
		send_record(1'b0, pack_record(8'h7F, 16'hFF00, 16'h00FF, 16'hEDCB));
		// one packet of RECORDS_PER_PACKET records builds up over the three phases
		send_dump(40, 0, 1'b1);

		send_idle_pct = 73;
		recv_idle_pct = 15;
		write_stamp($urandom);
		send_dump(45, 0, 1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_stamp(32'h0000_0000);
		send_dump(15, 0, 1'b0);
		write_stamp($urandom);
		send_dump(8, 25, 1'b1);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d records in %0d packets (%0d words), %0d dump wraps",
			records_seen, packets_seen, bytes_seen, dump_wraps);
		$display("timestamps all-ones, zero and random; stalls on both sides, %0d-cycle hold-off",
			HOLD_CYCLES);
		if (errors == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
